/* rtl/tmrld_pkg.sv */
// Shared types and constants for the tile map run-length decoder.
// No dependencies; used by tmrld_cursor, the top level and the testbench.
package tmrld_pkg;

  localparam int CUR_W = 7;

  localparam logic [3:0] CODE_EMPTY  = 4'd0;
  localparam logic [3:0] CODE_WALL   = 4'd1;
  localparam logic [3:0] CODE_SPIKES = 4'd2;
  localparam logic [3:0] CODE_HERO   = 4'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [7:0] CMD_CLASS_MASK = 8'hc0;
  localparam logic [7:0] CMD_EMPTY      = 8'h00;
  localparam logic [7:0] CMD_WALL       = 8'h40;
  localparam logic [7:0] CMD_SPIKE_MASK = 8'hf0;
  localparam logic [7:0] CMD_SPIKE      = 8'h80;
  localparam logic [7:0] CMD_SPECIAL_LO = 8'hc0;
  localparam logic [7:0] CMD_SPECIAL_HI = 8'hc5;

  typedef struct packed {
    logic             no_room;
    logic [CUR_W-1:0] tile_row;
    logic [CUR_W-1:0] tile_col;
    logic [CUR_W-1:0] next_col;
  } cur_step_t;

endpackage

/* rtl/tmrld_cursor.sv */
// Cursor step unit: wraps the raster cursor and detects a full grid.
// Depends on tmrld_pkg.
module tmrld_cursor #(
  parameter int COLS = 32,
  parameter int ROWS = 16
) (
  input  logic [tmrld_pkg::CUR_W-1:0] cur_col,
  input  logic [tmrld_pkg::CUR_W-1:0] cur_row,
  output tmrld_pkg::cur_step_t        step
);

  localparam logic [tmrld_pkg::CUR_W-1:0] COLS_V = tmrld_pkg::CUR_W'(COLS);
  localparam logic [tmrld_pkg::CUR_W-1:0] ROWS_V = tmrld_pkg::CUR_W'(ROWS);

  logic                        wrap;
  logic [tmrld_pkg::CUR_W-1:0] row_inc;

  assign wrap    = (cur_col >= COLS_V);
  assign row_inc = cur_row + tmrld_pkg::CUR_W'(1);

  always_comb begin
    step.no_room  = wrap && (row_inc >= ROWS_V);
    step.tile_row = wrap ? row_inc : cur_row;
    step.tile_col = wrap ? '0 : cur_col;
    step.next_col = step.tile_col + tmrld_pkg::CUR_W'(1);
  end

endmodule

/* rtl/tile_map_run_length_decoder_unit.sv */
// Tile map run-length decoder: expands map command bytes into raster tile writes,
// one tile per cycle unless stalled, via one cursor step unit and a small sequencer.
// Depends on tmrld_pkg and tmrld_cursor.
//
// A request with action 0 restarts the map and yields no result. A command
// request yields 1 to 64 results, one per cycle while out_ready is high; the
// block is busy from acceptance until its final result is loaded into the
// output register. The single cursor step unit places each tile in turn.
module tile_map_run_length_decoder_unit #(
  parameter int COLS = 32,
  parameter int ROWS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_map_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_tile,
  output logic [3:0] out_tile_code,
  output logic [5:0] out_tile_row,
  output logic [5:0] out_tile_col,
  output logic [1:0] out_status,
  output logic       out_last_of_run
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_REPLY
  } state_t;

  state_t                      state_r;
  logic [tmrld_pkg::CUR_W-1:0] col_r;
  logic [tmrld_pkg::CUR_W-1:0] row_r;
  logic                        full_r;
  logic                        bad_r;
  logic [3:0]                  code_r;
  logic [6:0]                  cnt_r;
  logic [1:0]                  reply_r;

  logic                        out_valid_r;
  logic                        has_tile_r;
  logic [3:0]                  tile_code_r;
  logic [5:0]                  tile_row_r;
  logic [5:0]                  tile_col_r;
  logic [1:0]                  status_r;
  logic                        last_r;

  logic                        load;
  logic                        emit;
  logic                        dec_ok;
  logic [3:0]                  dec_code;
  logic [6:0]                  dec_cnt;
  tmrld_pkg::cur_step_t        step;

  tmrld_cursor #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_cursor (
    .cur_col(col_r),
    .cur_row(row_r),
    .step   (step)
  );

  always_comb begin
    dec_ok   = 1'b1;
    dec_code = tmrld_pkg::CODE_EMPTY;
    dec_cnt  = 7'd1;
    priority if ((in_map_byte & tmrld_pkg::CMD_CLASS_MASK) == tmrld_pkg::CMD_EMPTY) begin
      dec_code = tmrld_pkg::CODE_EMPTY;
      dec_cnt  = {1'b0, in_map_byte[5:0]} + 7'd1;
    end else if ((in_map_byte & tmrld_pkg::CMD_CLASS_MASK) == tmrld_pkg::CMD_WALL) begin
      dec_code = tmrld_pkg::CODE_WALL;
      dec_cnt  = {1'b0, in_map_byte[5:0]} + 7'd1;
    end else if ((in_map_byte & tmrld_pkg::CMD_SPIKE_MASK) == tmrld_pkg::CMD_SPIKE) begin
      dec_code = tmrld_pkg::CODE_SPIKES;
      dec_cnt  = {3'b000, in_map_byte[3:0]} + 7'd1;
    end else if (in_map_byte >= tmrld_pkg::CMD_SPECIAL_LO &&
                 in_map_byte <= tmrld_pkg::CMD_SPECIAL_HI) begin
      dec_code = tmrld_pkg::CODE_HERO + {1'b0, in_map_byte[2:0]};
    end else begin
      dec_ok = 1'b0;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign load     = !out_valid_r || out_ready;
  assign emit     = load && (state_r == ST_RUN || state_r == ST_REPLY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      full_r      <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_action) begin
              col_r  <= '0;
              row_r  <= '0;
              full_r <= 1'b0;
              bad_r  <= 1'b0;
            end else if (bad_r) begin
              reply_r <= tmrld_pkg::STATUS_BAD;
              state_r <= ST_REPLY;
            end else if (full_r) begin
              reply_r <= tmrld_pkg::STATUS_FULL;
              state_r <= ST_REPLY;
            end else if (!dec_ok) begin
              bad_r   <= 1'b1;
              reply_r <= tmrld_pkg::STATUS_BAD;
              state_r <= ST_REPLY;
            end else begin
              code_r  <= dec_code;
              cnt_r   <= dec_cnt;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (load) begin
            if (step.no_room) begin
              full_r      <= 1'b1;
              has_tile_r  <= 1'b0;
              tile_code_r <= '0;
              tile_row_r  <= '0;
              tile_col_r  <= '0;
              status_r    <= tmrld_pkg::STATUS_FULL;
              last_r      <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              has_tile_r  <= 1'b1;
              tile_code_r <= code_r;
              tile_row_r  <= step.tile_row[5:0];
              tile_col_r  <= step.tile_col[5:0];
              status_r    <= tmrld_pkg::STATUS_OK;
              last_r      <= (cnt_r == 7'd1);
              col_r       <= step.next_col;
              row_r       <= step.tile_row;
              cnt_r       <= cnt_r - 7'd1;
              if (cnt_r == 7'd1) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        ST_REPLY: begin
          if (load) begin
            has_tile_r  <= 1'b0;
            tile_code_r <= '0;
            tile_row_r  <= '0;
            tile_col_r  <= '0;
            status_r    <= reply_r;
            last_r      <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_has_tile    = has_tile_r;
  assign out_tile_code   = tile_code_r;
  assign out_tile_row    = tile_row_r;
  assign out_tile_col    = tile_col_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;

`ifndef ASSERT_OFF
  a_tile_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_tile) |-> (out_status == tmrld_pkg::STATUS_OK))
    else $error("tile result with non-ok status");

  a_tile_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_tile) |-> (out_tile_row < ROWS && out_tile_col < COLS))
    else $error("tile position outside grid");

  a_flag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_tile) |-> out_last_of_run)
    else $error("status result not marked last");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action) |=> !in_ready)
    else $error("command request did not start sequencer");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench for tile_map_run_length_decoder_unit: directed table, then random map streams,
// every tile write checked against an in-bench decoder model. Depends on tmrld_pkg and the unit.
module tb;

  localparam int GRID_COLS       = 32;
  localparam int GRID_ROWS       = 16;
  localparam int RESET_CYCLES    = 8;
  localparam int RAND_ITEMS      = 245;
  localparam int PAUSE_ITEM      = 60;
  localparam int QUIET_ITEM_LO   = 150;
  localparam int QUIET_ITEM_HI   = 200;
  localparam int HOLD_AT         = 1500;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_RCV_LO    = 3000;
  localparam int QUIET_RCV_HI    = 4500;
  localparam int DRAIN_CYCLES    = 80;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    logic       has_tile;
    logic [3:0] tile_code;
    logic [5:0] tile_row;
    logic [5:0] tile_col;
    logic [1:0] status;
    logic       last_of_run;
  } tile_wr_t;

  typedef struct {
    bit         action;
    logic [7:0] map_byte;
    bit         typed;
    tile_wr_t   write;
  } stim_row_t;

  localparam tile_wr_t NO_TYPED_WRITE = '0;
  localparam tile_wr_t HERO_AT_ORIGIN = '{has_tile: 1'b1, tile_code: tmrld_pkg::CODE_HERO,
                                          tile_row: 6'd0, tile_col: 6'd0,
                                          status: tmrld_pkg::STATUS_OK, last_of_run: 1'b1};
  localparam tile_wr_t BAD_CMD_WRITE  = '{has_tile: 1'b0, tile_code: 4'd0, tile_row: 6'd0,
                                          tile_col: 6'd0, status: tmrld_pkg::STATUS_BAD,
                                          last_of_run: 1'b1};
  localparam tile_wr_t FULL_WRITE     = '{has_tile: 1'b0, tile_code: 4'd0, tile_row: 6'd0,
                                          tile_col: 6'd0, status: tmrld_pkg::STATUS_FULL,
                                          last_of_run: 1'b1};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_action;
  logic [7:0] in_map_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_has_tile;
  logic [3:0] out_tile_code;
  logic [5:0] out_tile_row;
  logic [5:0] out_tile_col;
  logic [1:0] out_status;
  logic       out_last_of_run;

  tile_wr_t   pending_writes[$];
  stim_row_t  dir_rows[$];
  logic [6:0] map_col  = '0;
  logic [6:0] map_row  = '0;
  bit         map_full = 1'b0;
  bit         map_bad  = 1'b0;
  int         err_count = 0;
  int         idle_cycles = 0;
  int         rcv_cycle = 0;
  tile_wr_t   got_write;
  tile_wr_t   exp_write;

  tile_map_run_length_decoder_unit #(
    .COLS(GRID_COLS),
    .ROWS(GRID_ROWS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_map_byte    (in_map_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_has_tile   (out_has_tile),
    .out_tile_code  (out_tile_code),
    .out_tile_row   (out_tile_row),
    .out_tile_col   (out_tile_col),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stim_row_t stim_row(bit act, logic [7:0] cmd, bit typed, tile_wr_t wr);
    stim_row_t r;
    r.action   = act;
    r.map_byte = cmd;
    r.typed    = typed;
    r.write    = wr;
    return r;
  endfunction

  task automatic predict_tile_writes(input bit act, input logic [7:0] cmd, output int n_writes);
    logic [3:0] code;
    int         count;
    int         idx;
    tile_wr_t   wr;
    n_writes = 0;
    count    = 1;
    if (!act) begin
      map_col  = '0;
      map_row  = '0;
      map_full = 1'b0;
      map_bad  = 1'b0;
      return;
    end
    if (map_bad) begin
      pending_writes.push_back(BAD_CMD_WRITE);
      n_writes = 1;
      return;
    end
    if (map_full) begin
      pending_writes.push_back(FULL_WRITE);
      n_writes = 1;
      return;
    end
    if ((cmd & tmrld_pkg::CMD_CLASS_MASK) == tmrld_pkg::CMD_EMPTY) begin
      code  = tmrld_pkg::CODE_EMPTY;
      count = int'(cmd[5:0]) + 1;
    end else if ((cmd & tmrld_pkg::CMD_CLASS_MASK) == tmrld_pkg::CMD_WALL) begin
      code  = tmrld_pkg::CODE_WALL;
      count = int'(cmd[5:0]) + 1;
    end else if ((cmd & tmrld_pkg::CMD_SPIKE_MASK) == tmrld_pkg::CMD_SPIKE) begin
      code  = tmrld_pkg::CODE_SPIKES;
      count = int'(cmd[3:0]) + 1;
    end else if (cmd >= tmrld_pkg::CMD_SPECIAL_LO && cmd <= tmrld_pkg::CMD_SPECIAL_HI) begin
      code = tmrld_pkg::CODE_HERO + 4'(cmd - tmrld_pkg::CMD_SPECIAL_LO);
    end else begin
      map_bad = 1'b1;
      pending_writes.push_back(BAD_CMD_WRITE);
      n_writes = 1;
      return;
    end
    for (int i = 0; i < count; i++) begin
      if (int'(map_col) >= GRID_COLS) begin
        if (int'(map_row) + 1 >= GRID_ROWS) begin
          map_full = 1'b1;
          break;
        end
        map_col = '0;
        map_row = map_row + 7'd1;
      end
      wr = '{has_tile: 1'b1, tile_code: code, tile_row: map_row[5:0], tile_col: map_col[5:0],
             status: tmrld_pkg::STATUS_OK, last_of_run: 1'b0};
      pending_writes.push_back(wr);
      n_writes++;
      map_col = map_col + 7'd1;
    end
    if (map_full) begin
      pending_writes.push_back(FULL_WRITE);
      n_writes++;
    end else begin
      idx = pending_writes.size() - 1;
      pending_writes[idx].last_of_run = 1'b1;
    end
  endtask

  task automatic offer_request(input bit act, input logic [7:0] cmd, input bit may_idle,
                               output int n_writes);
    if (may_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_map_byte <= cmd;
    do @(posedge clk); while (!in_ready);
    predict_tile_writes(act, cmd, n_writes);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rcv_cycle++;
      if (rcv_cycle <= RESET_CYCLES) begin
        out_ready <= 1'b0;
      end else if (rcv_cycle >= HOLD_AT && rcv_cycle < HOLD_AT + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else if (rcv_cycle >= QUIET_RCV_LO && rcv_cycle < QUIET_RCV_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_write = '{has_tile: out_has_tile, tile_code: out_tile_code, tile_row: out_tile_row,
                    tile_col: out_tile_col, status: out_status, last_of_run: out_last_of_run};
      if (pending_writes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected tile write: has=%0d code=%0d row=%0d col=%0d",
                 $time, got_write.has_tile, got_write.tile_code, got_write.tile_row,
                 got_write.tile_col, " st=%0d last=%0d",
                 got_write.status, got_write.last_of_run);
      end else begin
        exp_write = pending_writes.pop_front();
        if (got_write !== exp_write) begin
          err_count++;
          $display("%0t: mismatch exp has=%0d code=%0d row=%0d col=%0d st=%0d last=%0d",
                   $time, exp_write.has_tile, exp_write.tile_code, exp_write.tile_row,
                   exp_write.tile_col, exp_write.status, exp_write.last_of_run,
                   ", got has=%0d code=%0d row=%0d col=%0d st=%0d last=%0d",
                   got_write.has_tile, got_write.tile_code, got_write.tile_row,
                   got_write.tile_col, got_write.status, got_write.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit         act;
    logic [7:0] cmd;
    int         space;
    int         n_writes;
    int         r;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= 1'b0;
    in_map_byte <= 8'h00;

    dir_rows.push_back(stim_row(1'b0, 8'h00, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, tmrld_pkg::CMD_SPECIAL_LO, 1'b1, HERO_AT_ORIGIN));
    for (int s = 1; s <= 5; s++)
      dir_rows.push_back(stim_row(1'b1, tmrld_pkg::CMD_SPECIAL_LO + 8'(s), 1'b0,
                                  NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h00, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h3f, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h40, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h80, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h8f, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, tmrld_pkg::CMD_SPECIAL_HI + 8'd1, 1'b1, BAD_CMD_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'hff, 1'b1, BAD_CMD_WRITE));
    dir_rows.push_back(stim_row(1'b0, 8'hff, 1'b0, NO_TYPED_WRITE));
    for (int s = 0; s < 7; s++)
      dir_rows.push_back(stim_row(1'b1, 8'h7f, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h3e, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, 8'h81, 1'b0, NO_TYPED_WRITE));
    dir_rows.push_back(stim_row(1'b1, tmrld_pkg::CMD_SPECIAL_LO, 1'b1, FULL_WRITE));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer_request(dir_rows[i].action, dir_rows[i].map_byte, 1'b1, n_writes);
      if (dir_rows[i].typed) begin
        repeat (n_writes) void'(pending_writes.pop_back());
        pending_writes.push_back(dir_rows[i].write);
      end
    end

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == PAUSE_ITEM) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (map_bad || map_full) begin
        act = ($urandom_range(2) != 0);
        cmd = 8'($urandom());
      end else if (r < 3) begin
        act = 1'b0;
        cmd = 8'($urandom());
      end else if (r < 6) begin
        act = 1'b1;
        cmd = 8'($urandom_range(8'h90, 8'hf9));
        if (cmd >= tmrld_pkg::CMD_SPECIAL_LO) cmd = cmd + 8'd6;
      end else begin
        act   = 1'b1;
        space = (GRID_ROWS - 1 - int'(map_row)) * GRID_COLS + (GRID_COLS - int'(map_col));
        if (space >= 1 && space <= 64 && $urandom_range(2) == 0) begin
          cmd = {1'b0, 1'($urandom_range(1)), 6'(space - 1)};
        end else begin
          case ($urandom_range(3))
            0:       cmd = tmrld_pkg::CMD_EMPTY | 8'($urandom_range(63));
            1:       cmd = tmrld_pkg::CMD_WALL | 8'($urandom_range(63));
            2:       cmd = tmrld_pkg::CMD_SPIKE | 8'($urandom_range(15));
            default: cmd = tmrld_pkg::CMD_SPECIAL_LO + 8'($urandom_range(5));
          endcase
        end
      end
      offer_request(act, cmd, !(k >= QUIET_ITEM_LO && k < QUIET_ITEM_HI), n_writes);
    end

    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tmrld_pkg.sv
rtl/tmrld_cursor.sv
rtl/tile_map_run_length_decoder_unit.sv
bench/tb.sv
